[rtl/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg
// shared types and codes for the json event tokenizer
// ----------------------------------------------------------------------------
package jet_pkg;

   localparam int unsigned OffW   = 24;
   localparam int unsigned DepthW = 7;

   typedef enum logic [2:0] {
      MODE_STRUCT  = 3'd0,
      MODE_STRING  = 3'd1,
      MODE_ESCAPE  = 3'd2,
      MODE_PRIM    = 3'd3,
      MODE_DISCARD = 3'd4
   } mode_type;

   localparam logic [2:0] EV_BEGIN  = 3'd0;
   localparam logic [2:0] EV_END    = 3'd1;
   localparam logic [2:0] EV_STRING = 3'd2;
   localparam logic [2:0] EV_PRIM   = 3'd3;
   localparam logic [2:0] EV_DONE   = 3'd4;
   localparam logic [2:0] EV_ERROR  = 3'd5;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_CLOSE    = 3'd1;
   localparam logic [2:0] ERR_STRING   = 3'd2;
   localparam logic [2:0] ERR_PRIM     = 3'd3;
   localparam logic [2:0] ERR_DEEP     = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [2:0]        event_kind;
      logic [2:0]        error_code;
      logic              key_present;
      logic [OffW-1:0]   key_begin;
      logic [OffW-1:0]   key_end;
      logic              span_present;
      logic [OffW-1:0]   span_begin;
      logic [OffW-1:0]   span_end;
      logic [DepthW-1:0] nest_depth;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic            set;
      logic [OffW-1:0] b;
      logic [OffW-1:0] e;
   } span_type;

endpackage

[rtl/json_event_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// json_event_tokenizer_unit
// streaming json tokenizer: one byte in per item, parse events out
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one document byte per item, or an end item (end_mark)
//   rsp_ channel: zero, one or two event items per input item; the last one
//     of an input item carries last_of_run
//   a byte is processed in the cycle it is accepted; its first event shows up
//     in the output register in the next cycle, a second one waits in pend_ff
//   throughput: one byte per cycle while the receiver does not stall; a byte that
//     yields two events (primitive closed by a bracket) holds the input while pend_ff is set
//   the name stack lives in a ram with registered read; the top entry is kept
//     in a register (top_ff) and a close reads the entry below it, which is
//     taken straight from the ram output in the next cycle, so pops need no
//     wait, back to back or not
//   reset clears mode, offset, level and spans; the stack needs no clearing
//   a stalled receiver holds the output register and the input stops too
// ----------------------------------------------------------------------------
module json_event_tokenizer_unit #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jet_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jet_pkg::rsp_type rsp_data
);
   import jet_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

   // architectural state
   mode_type        mode_ff, mode_in;
   logic [OffW-1:0] off_ff, off_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   span_type        key_ff, key_in, text_ff, text_in, top_ff, top_in;
   logic [OffW-1:0] tok_ff, tok_in;
   logic            refill_ff, refill_in;   // ram read pending for top_ff
   // second event of a primitive closed by a bracket
   logic            pend_ff, pend_in;
   rsp_type         pend_rsp_ff, pend_rsp_in;
   // output register
   logic            ov_ff, ov_in;
   rsp_type         out_ff, out_in;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_wa, ram_ra;
   span_type        ram_wd, ram_rd;
   span_type        top_now;

   jet_ram #(.WIDTH($bits(span_type)), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_en(ram_re), .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign top_now = refill_ff ? ram_rd : top_ff;

   logic out_free;
   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = out_free && !pend_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   function automatic rsp_type mk(input logic [2:0] k, input logic [2:0] er,
                                  input span_type ks, input span_type vs,
                                  input logic [LW-1:0] lv);
      rsp_type r;
      r.event_kind   = k;
      r.error_code   = er;
      r.key_present  = ks.set;
      r.key_begin    = ks.set ? ks.b : '0;
      r.key_end      = ks.set ? ks.e : '0;
      r.span_present = vs.set;
      r.span_begin   = vs.set ? vs.b : '0;
      r.span_end     = vs.set ? vs.e : '0;
      r.nest_depth   = DepthW'(lv);
      r.last_of_run  = 1'b1;
      return r;
   endfunction

   logic       acc;
   logic [7:0] c;
   logic       is_sb;            // byte goes through the structure logic
   logic       n1;               // first event slot used
   rsp_type    e1, e2;
   logic       n2;
   span_type   none, pv;
   logic [OffW-1:0] pos;

   always_comb begin
      acc        = req_valid && req_ready;
      c          = req_data.data_byte;
      none       = '0;
      pos        = off_ff;
      mode_in    = mode_ff;
      off_in     = off_ff;
      lvl_in     = lvl_ff;
      key_in     = key_ff;
      text_in    = text_ff;
      top_in     = top_now;
      tok_in     = tok_ff;
      refill_in  = 1'b0;
      pend_in    = pend_ff;
      pend_rsp_in = pend_rsp_ff;
      ov_in      = ov_ff && !rsp_ready;
      out_in     = out_ff;
      ram_we     = 1'b0;
      ram_wa     = AW'(lvl_ff);
      ram_wd     = text_ff;
      ram_re     = 1'b0;
      ram_ra     = '0;
      is_sb      = 1'b0;
      n1         = 1'b0;
      n2         = 1'b0;
      e1         = '0;
      e2         = '0;
      pv         = '0;

      if (pend_ff && out_free) begin
         ov_in   = 1'b1;
         out_in  = pend_rsp_ff;
         pend_in = 1'b0;
      end

      if (acc) begin
         if (req_data.end_mark) begin
            unique case (mode_ff)
               MODE_STRING, MODE_ESCAPE: begin
                  n1 = 1'b1; e1 = mk(EV_ERROR, ERR_STRING, none, none, lvl_ff);
               end
               MODE_PRIM: begin
                  n1 = 1'b1; e1 = mk(EV_ERROR, ERR_PRIM, none, none, lvl_ff);
               end
               MODE_STRUCT: begin
                  n1 = 1'b1; e1 = mk(EV_DONE, ERR_NONE, none, none, lvl_ff);
               end
               default: ;
            endcase
            mode_in = MODE_STRUCT;
            off_in  = '0;
            lvl_in  = '0;
            key_in  = none;
            text_in = none;
            tok_in  = '0;
         end else if (mode_ff == MODE_DISCARD) begin
         end else if (&off_ff) begin
            n1 = 1'b1; e1 = mk(EV_ERROR, ERR_OVERFLOW, none, none, lvl_ff);
            mode_in = MODE_DISCARD;
         end else begin
            off_in = off_ff + 1'b1;
            unique case (mode_ff)
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     pv = '{set: 1'b1, b: tok_ff, e: pos};
                     text_in = pv;
                     n1 = 1'b1; e1 = mk(EV_STRING, ERR_NONE, key_ff, pv, lvl_ff);
                     mode_in = MODE_STRUCT;
                  end else if (c == CH_BSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end
               end
               MODE_ESCAPE: mode_in = MODE_STRING;
               MODE_PRIM: begin
                  if (c == CH_RBRACK || c == CH_RBRACE || c == CH_TAB || c == CH_CR
                      || c == CH_LF || c == CH_SPACE || c == CH_COMMA) begin
                     pv = '{set: 1'b1, b: tok_ff, e: pos};
                     n1 = 1'b1; e1 = mk(EV_PRIM, ERR_NONE, key_ff, pv, lvl_ff);
                     text_in = pv;
                     mode_in = MODE_STRUCT;
                     is_sb = 1'b1;
                  end
               end
               default: is_sb = 1'b1;
            endcase
            if (is_sb) begin
               // structure handling, with text as updated by a closed primitive
               priority if (c == CH_LBRACE || c == CH_LBRACK) begin
                  if (lvl_ff == LW'(STACK_DEPTH)) begin
                     n2 = 1'b1; e2 = mk(EV_ERROR, ERR_DEEP, none, none, lvl_ff);
                     mode_in = MODE_DISCARD;
                  end else begin
                     // previous top goes to ram; new top held in register
                     ram_we = (lvl_ff != '0);
                     ram_wa = AW'(lvl_ff - 1'b1);
                     ram_wd = top_now;
                     top_in = text_in;
                     lvl_in = lvl_ff + 1'b1;
                     n2 = 1'b1;
                     e2 = mk(EV_BEGIN, ERR_NONE, none, text_in, lvl_in);
                     key_in  = none;
                     text_in = none;
                  end
               end else if (c == CH_RBRACE || c == CH_RBRACK) begin
                  if (lvl_ff == '0) begin
                     n2 = 1'b1; e2 = mk(EV_ERROR, ERR_CLOSE, none, none, lvl_ff);
                     mode_in = MODE_DISCARD;
                  end else begin
                     lvl_in  = lvl_ff - 1'b1;
                     key_in  = none;
                     text_in = top_now;
                     n2 = 1'b1;
                     e2 = mk(EV_END, ERR_NONE, none, top_now, lvl_in);
                     if (lvl_ff > LW'(1)) begin
                        ram_re    = 1'b1;
                        ram_ra    = AW'(lvl_ff - LW'(2));
                        refill_in = 1'b1;
                     end
                  end
               end else if (c == CH_QUOTE) begin
                  tok_in  = pos + 1'b1;
                  mode_in = MODE_STRING;
               end else if (c == CH_MINUS || c == CH_T || c == CH_F || c == CH_N
                            || (c >= CH_0 && c <= CH_9)) begin
                  tok_in  = pos;
                  mode_in = MODE_PRIM;
               end else if (c == CH_COLON) begin
                  key_in = text_in;
               end else if (c == CH_COMMA) begin
                  key_in = none;
               end else begin
                  // any other byte is ignored between tokens
               end
            end
         end

         if (n1 && n2) begin
            e1.last_of_run = 1'b0;
            ov_in = 1'b1; out_in = e1;
            pend_in = 1'b1; pend_rsp_in = e2;
         end else if (n1) begin
            ov_in = 1'b1; out_in = e1;
         end else if (n2) begin
            ov_in = 1'b1; out_in = e2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_STRUCT;
         off_ff    <= '0;
         lvl_ff    <= '0;
         key_ff    <= '0;
         text_ff   <= '0;
         tok_ff    <= '0;
         refill_ff <= 1'b0;
         pend_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         off_ff    <= off_in;
         lvl_ff    <= lvl_in;
         key_ff    <= key_in;
         text_ff   <= text_in;
         tok_ff    <= tok_in;
         refill_ff <= refill_in;
         pend_ff   <= pend_in;
         ov_ff     <= ov_in;
      end
      top_ff      <= top_in;
      pend_rsp_ff <= pend_rsp_in;
      out_ff      <= out_in;
   end

`ifndef ASSERT_OFF
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("output changed while stalled");
   a_no_accept_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_ready)
      else $error("input taken with second event pending");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(STACK_DEPTH))
      else $error("level beyond stack");
   a_pend_last: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> pend_rsp_ff.last_of_run)
      else $error("pending event not last");
`endif
endmodule

[rtl/jet_ram.sv]
// ----------------------------------------------------------------------------
// jet_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module jet_ram #(
   parameter int unsigned WIDTH = 49,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
